// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/fiws_pkg.sv -----
//------------------------------------------------------------------------------
// fiws_pkg
// Shared constants, types and command/status structures for the frame
// interval window statistics block.
//------------------------------------------------------------------------------
`default_nettype none
package fiws_pkg;

   localparam int unsigned WindowDepthDefault = 128;
   localparam int unsigned TsWidth    = 63;
   localparam int unsigned IvWidth    = 32;
   localparam int unsigned RateWidth  = 38;
   localparam int unsigned CountWidth = 8;
   localparam int unsigned SumWidth   = 45;
   localparam int unsigned DivWidth   = 64;

   localparam logic [RateWidth-1:0] RateNum = 38'd256000000000;
   localparam logic [IvWidth-1:0]   IvMax   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic capture;     // register input item, compute interval
      logic push;        // write history, update sum/min/max, read evicted first
      logic scan_start;  // begin window rescan
      logic scan_step;   // consume one read datum during rescan
      logic div_start;   // start both divisions
      logic load_out;    // register result
   } fiws_cmd_type;

   typedef struct packed {
      logic first;       // item is the first after reset
      logic need_scan;   // evicted value equalled the old min or max
      logic scan_done;   // rescan complete
      logic div_done;    // divisions finished
   } fiws_sts_type;

endpackage
`default_nettype wire

// ----- design/fiws_if.sv -----
//------------------------------------------------------------------------------
// fiws_req_if / fiws_rsp_if
// Valid/ready channels for input items and result items.
//------------------------------------------------------------------------------
`default_nettype none
interface fiws_req_if;
   import fiws_pkg::*;
   logic               valid;
   logic               ready;
   logic [TsWidth-1:0] timestamp_ns;
   modport source (output valid, output timestamp_ns, input ready);
   modport sink   (input valid, input timestamp_ns, output ready);
endinterface

interface fiws_rsp_if;
   import fiws_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [IvWidth-1:0]    interval_ns;
   logic [RateWidth-1:0]  rate_q8;
   logic [RateWidth-1:0]  avg_rate_q8;
   logic [IvWidth-1:0]    min_interval_ns;
   logic [IvWidth-1:0]    max_interval_ns;
   logic [CountWidth-1:0] window_count;
   modport source (output valid, output interval_ns, output rate_q8, output avg_rate_q8,
                   output min_interval_ns, output max_interval_ns, output window_count,
                   input ready);
   modport sink   (input valid, input interval_ns, input rate_q8, input avg_rate_q8,
                   input min_interval_ns, input max_interval_ns, input window_count,
                   output ready);
endinterface
`default_nettype wire

// ----- design/fiws_ram.sv -----
//------------------------------------------------------------------------------
// fiws_ram
// Generic single-port-write, single-port-read RAM with registered read.
//------------------------------------------------------------------------------
`default_nettype none
module fiws_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- design/fiws_div.sv -----
//------------------------------------------------------------------------------
// fiws_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Quotient is zero when the divisor is zero.
//------------------------------------------------------------------------------
`default_nettype none
module fiws_div
   import fiws_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DivWidth-1:0] dividend,
   input  wire logic [SumWidth-1:0] divisor,
   output logic                     done,
   output logic     [DivWidth-1:0]  quotient
);
   localparam int unsigned CntWidth = $clog2(DivWidth + 1);

   logic [DivWidth-1:0] quo_ff, quo_in;
   logic [SumWidth:0]   rem_ff, rem_in;
   logic [SumWidth-1:0] dsr_ff, dsr_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [SumWidth:0]   trial;
   logic [SumWidth:0]   diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[SumWidth-1:0], quo_ff[DivWidth-1]};
      diff    = trial - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CntWidth'(DivWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract if it fits
         if (!diff[SumWidth]) begin
            rem_in = diff;
            quo_in = {quo_ff[DivWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DivWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = !busy_ff && !start;
   assign quotient = (dsr_ff == '0) ? '0 : quo_ff;
endmodule
`default_nettype wire

// ----- design/fiws_datapath.sv -----
//------------------------------------------------------------------------------
// fiws_datapath
// Interval computation, history RAM, running sum, min/max, rescan and the
// two rate divisions.
//------------------------------------------------------------------------------
`default_nettype none
module fiws_datapath
   import fiws_pkg::*;
#(
   parameter int unsigned WINDOW_DEPTH = WindowDepthDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fiws_cmd_type          cmd,
   output fiws_sts_type               sts,
   input  wire logic [TsWidth-1:0]    timestamp_ns,
   output logic      [IvWidth-1:0]    interval_ns,
   output logic      [RateWidth-1:0]  rate_q8,
   output logic      [RateWidth-1:0]  avg_rate_q8,
   output logic      [IvWidth-1:0]    min_interval_ns,
   output logic      [IvWidth-1:0]    max_interval_ns,
   output logic      [CountWidth-1:0] window_count
);
   localparam int unsigned AddrWidth = $clog2(WINDOW_DEPTH);
   localparam int unsigned FillWidth = $clog2(WINDOW_DEPTH + 1);

   logic                 started_ff, started_in;
   logic [TsWidth-1:0]   last_ff, last_in;
   logic [IvWidth-1:0]   iv_ff, iv_in;
   logic [AddrWidth-1:0] wpos_ff, wpos_in;
   logic [FillWidth-1:0] fill_ff, fill_in;
   logic [SumWidth-1:0]  sum_ff, sum_in;
   logic [IvWidth-1:0]   min_ff, min_in;
   logic [IvWidth-1:0]   max_ff, max_in;
   logic                 scan_ff, scan_in;
   logic [FillWidth-1:0] sidx_ff, sidx_in;
   logic                 first_ff, first_in;
   logic [IvWidth-1:0]   o_iv_ff;
   logic [RateWidth-1:0] o_rate_ff, o_avg_ff;
   logic [IvWidth-1:0]   o_min_ff, o_max_ff;
   logic [CountWidth-1:0] o_cnt_ff;

   logic [AddrWidth-1:0] rd_addr;
   logic [IvWidth-1:0]   rd_data;
   logic                 full;
   logic [TsWidth:0]     diff;
   logic                 div1_done, div2_done;
   logic [DivWidth-1:0]  q1, q2, avg_num;
   logic [RateWidth-1:0] avg_sat;

   assign full = (fill_ff == FillWidth'(WINDOW_DEPTH));
   assign diff = {1'b0, timestamp_ns} - {1'b0, last_ff};

   // read evicted entry ahead of push; during scan read the next index
   always_comb begin
      if (scan_ff) begin
         rd_addr = sidx_ff[AddrWidth-1:0];
      end else begin
         rd_addr = wpos_ff;
      end
   end

   fiws_ram #(.WIDTH(IvWidth), .DEPTH(WINDOW_DEPTH)) u_hist (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (wpos_ff),
      .wr_data (iv_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      started_in = started_ff;
      last_in    = last_ff;
      iv_in      = iv_ff;
      wpos_in    = wpos_ff;
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      scan_in    = scan_ff;
      sidx_in    = sidx_ff;
      first_in   = first_ff;
      if (cmd.capture) begin
         first_in   = !started_ff;
         started_in = 1'b1;
         last_in    = timestamp_ns;
         if (diff[TsWidth]) begin
            iv_in = '0;
         end else if (diff[TsWidth-1:IvWidth] != '0) begin
            iv_in = IvMax;
         end else begin
            iv_in = diff[IvWidth-1:0];
         end
      end
      if (cmd.push) begin
         wpos_in = (wpos_ff == AddrWidth'(WINDOW_DEPTH - 1)) ? '0 : wpos_ff + 1'b1;
         sum_in  = sum_ff + SumWidth'(iv_ff);
         if (full) begin
            sum_in = sum_ff + SumWidth'(iv_ff) - SumWidth'(rd_data);
         end else begin
            fill_in = fill_ff + 1'b1;
         end
         if (fill_ff == '0) begin
            min_in = iv_ff;
            max_in = iv_ff;
         end else begin
            if (iv_ff < min_ff) min_in = iv_ff;
            if (iv_ff > max_ff) max_in = iv_ff;
         end
      end
      if (cmd.scan_start) begin
         scan_in = 1'b1;
         sidx_in = '0;
      end
      if (cmd.scan_step) begin
         // rd_data holds entry sidx-1 (registered RAM read)
         if (sidx_ff == FillWidth'(1)) begin
            min_in = rd_data;
            max_in = rd_data;
         end else begin
            if (rd_data < min_ff) min_in = rd_data;
            if (rd_data > max_ff) max_in = rd_data;
         end
      end
      if (scan_ff) begin
         if (sidx_ff == fill_ff) begin
            scan_in = 1'b0;
         end else begin
            sidx_in = sidx_ff + 1'b1;
         end
      end
   end

   assign avg_num = DivWidth'(RateNum) * DivWidth'(fill_ff);

   fiws_div u_div_rate (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (DivWidth'(RateNum)),
      .divisor  (SumWidth'(iv_ff)),
      .done     (div1_done),
      .quotient (q1)
   );

   fiws_div u_div_avg (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (avg_num),
      .divisor  (sum_ff),
      .done     (div2_done),
      .quotient (q2)
   );

   assign avg_sat = (q2 > DivWidth'(RateNum)) ? RateNum : q2[RateWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         last_ff    <= '0;
         wpos_ff    <= '0;
         fill_ff    <= '0;
         sum_ff     <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         scan_ff    <= 1'b0;
         sidx_ff    <= '0;
         first_ff   <= 1'b0;
      end else begin
         started_ff <= started_in;
         last_ff    <= last_in;
         wpos_ff    <= wpos_in;
         fill_ff    <= fill_in;
         sum_ff     <= sum_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         scan_ff    <= scan_in;
         sidx_ff    <= sidx_in;
         first_ff   <= first_in;
      end
      iv_ff <= iv_in;
      if (cmd.load_out) begin
         if (first_ff) begin
            o_iv_ff   <= '0;
            o_rate_ff <= '0;
            o_avg_ff  <= '0;
            o_min_ff  <= '0;
            o_max_ff  <= '0;
            o_cnt_ff  <= '0;
         end else begin
            o_iv_ff   <= iv_ff;
            o_rate_ff <= q1[RateWidth-1:0];
            o_avg_ff  <= avg_sat;
            o_min_ff  <= min_ff;
            o_max_ff  <= max_ff;
            o_cnt_ff  <= CountWidth'(fill_ff);
         end
      end
   end

   assign sts.first     = first_ff;
   assign sts.need_scan = full && (rd_data == min_ff || rd_data == max_ff);
   assign sts.scan_done = !scan_ff;
   assign sts.div_done  = div1_done && div2_done;

   assign interval_ns     = o_iv_ff;
   assign rate_q8         = o_rate_ff;
   assign avg_rate_q8     = o_avg_ff;
   assign min_interval_ns = o_min_ff;
   assign max_interval_ns = o_max_ff;
   assign window_count    = o_cnt_ff;
endmodule
`default_nettype wire

// ----- design/fiws_ctrl.sv -----
//------------------------------------------------------------------------------
// fiws_ctrl
// Sequencer: capture, evicted read, push, optional rescan, divide, output; the first item skips to output.
//------------------------------------------------------------------------------
`default_nettype none
module fiws_ctrl
   import fiws_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire fiws_sts_type sts,
   output fiws_cmd_type      cmd
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_READ  = 7'b0000010,
      ST_PUSH  = 7'b0000100,
      ST_SCAN  = 7'b0001000,
      ST_DIVGO = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      scan_seen_ff, scan_seen_in;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      scan_seen_in = scan_seen_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            // wait for evicted entry read
            if (sts.first) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            if (sts.need_scan) begin
               cmd.scan_start = 1'b1;
               scan_seen_in   = 1'b0;
               state_in       = ST_SCAN;
            end else begin
               state_in = ST_DIVGO;
            end
         end
         ST_SCAN: begin
            // first cycle primes the read pipeline
            if (scan_seen_ff) cmd.scan_step = 1'b1;
            scan_seen_in = 1'b1;
            if (scan_seen_ff && sts.scan_done) begin
               cmd.scan_step = 1'b0;
               state_in      = ST_DIVGO;
            end
         end
         ST_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         scan_seen_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         scan_seen_ff <= scan_seen_in;
      end
   end

   assign rsp_valid = out_valid_ff;
endmodule
`default_nettype wire

// ----- design/frame_interval_window_stats.sv -----
// Each item passes capture, RAM read, push and the radix-2 serial divide; the first item
//   after reset skips push and divide. A history RAM rescan follows the push when the
//   evicted interval equalled the window min or max. A new item is taken only in idle.
// A finished result waits in the output register while the next item is taken.
// Reset: synchronous, active high; clears control and window state. History RAM
//   needs no clearing since entries are only read after being written.
//------------------------------------------------------------------------------
// frame_interval_window_stats
// Frame interval statistics over a sliding window of intervals.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module frame_interval_window_stats
   import fiws_pkg::*;
#(
   parameter int unsigned WINDOW_DEPTH = WindowDepthDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   fiws_req_if.sink  req,
   fiws_rsp_if.source rsp
);
   fiws_cmd_type cmd;
   fiws_sts_type sts;

   fiws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fiws_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .timestamp_ns    (req.timestamp_ns),
      .interval_ns     (rsp.interval_ns),
      .rate_q8         (rsp.rate_q8),
      .avg_rate_q8     (rsp.avg_rate_q8),
      .min_interval_ns (rsp.min_interval_ns),
      .max_interval_ns (rsp.max_interval_ns),
      .window_count    (rsp.window_count)
   );

   `ASSERT_CLK(a_min_le_max, clock, reset,
      !rsp.valid || (rsp.min_interval_ns <= rsp.max_interval_ns), "min above max")
   `ASSERT_CLK(a_one_cmd, clock, reset,
      $onehot0({cmd.capture, cmd.push, cmd.div_start, cmd.load_out}), "overlapping commands")
   `ASSERT_NEXT(a_load_valid, clock, reset, cmd.load_out, rsp.valid, "result not presented")
endmodule
`default_nettype wire
